// ===== hw/rtl/line_fir_replicate_border_defines.svh =====
// assertion macros shared by the line filter checkers
`ifndef LINE_FIR_REPLICATE_BORDER_DEFINES_SVH
`define LINE_FIR_REPLICATE_BORDER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define LFRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define LFRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lfrb_pkg.sv =====
// types and constants of the line filter with replicated border
package lfrb_pkg;

    localparam int PIX_W     = 8;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = COEF_W + PIX_W + 1;
    localparam int ACC_W     = 28;
    localparam int FRAC_W    = 14;
    localparam int HALF_W    = 3;
    localparam int SEEN_W    = 4;
    localparam int TAP_W     = 4;
    localparam int NUM_WORDS = 4;
    localparam int CFG_W     = 64;
    localparam int ADDR_W    = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_0     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_1     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_2     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_3     = 3'd4;

    localparam logic [HALF_W-1:0] HALF_RESET = 3'd1;
    localparam logic [SEEN_W-1:0] SEEN_MAX   = 4'hF;

    typedef logic [NUM_WORDS-1:0][CFG_W-1:0] t_coef_words;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_MAC,
        S_DRAIN,
        S_PUSH,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic             load;
        logic             hold_shift;
        logic             mac_step;
        logic             mac_clear;
        logic [TAP_W-1:0] tap;
        logic             push;
        logic             push_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [SEEN_W-1:0] seen;
        logic              slot_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/lfrb_cfg.sv =====
// configuration registers behind the apb port
module lfrb_cfg #(
    parameter int MAX_HALF_WIDTH = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lfrb_pkg::ADDR_W-1:0]         paddr,
    input  logic [lfrb_pkg::CFG_W-1:0]          pwdata,
    output logic [lfrb_pkg::CFG_W-1:0]          prdata,
    output logic                                pready,
    output logic [lfrb_pkg::HALF_W-1:0]         o_half,
    output lfrb_pkg::t_coef_words               o_coef
);

    logic [lfrb_pkg::HALF_W-1:0]    r_half;
    lfrb_pkg::t_coef_words          r_coef;
    logic [lfrb_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[lfrb_pkg::ADDR_W-1:lfrb_pkg::ADDR_W-lfrb_pkg::REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= lfrb_pkg::HALF_RESET;
            r_coef <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                lfrb_pkg::REG_HALF_WIDTH: r_half    <= pwdata[lfrb_pkg::HALF_W-1:0];
                lfrb_pkg::REG_COEF_0:     r_coef[0] <= pwdata;
                lfrb_pkg::REG_COEF_1:     r_coef[1] <= pwdata;
                lfrb_pkg::REG_COEF_2:     r_coef[2] <= pwdata;
                lfrb_pkg::REG_COEF_3:     r_coef[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lfrb_pkg::REG_HALF_WIDTH: prdata = lfrb_pkg::CFG_W'(r_half);
            lfrb_pkg::REG_COEF_0:     prdata = r_coef[0];
            lfrb_pkg::REG_COEF_1:     prdata = r_coef[1];
            lfrb_pkg::REG_COEF_2:     prdata = r_coef[2];
            lfrb_pkg::REG_COEF_3:     prdata = r_coef[3];
            default:                  prdata = '0;
        endcase
    end

    // a border wider than the window allows is used at its maximum
    assign o_half = (r_half > lfrb_pkg::HALF_W'(MAX_HALF_WIDTH))
                  ? lfrb_pkg::HALF_W'(MAX_HALF_WIDTH) : r_half;
    assign o_coef = r_coef;

endmodule

// ===== hw/rtl/lfrb_datapath.sv =====
// window shift line, shared multiply-accumulate unit and output register
module lfrb_datapath #(
    parameter int MAX_HALF_WIDTH = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lfrb_pkg::t_dp_cmd           i_cmd,
    output lfrb_pkg::t_dp_status        o_status,
    input  logic [lfrb_pkg::HALF_W-1:0] i_half,
    input  lfrb_pkg::t_coef_words       i_coef,
    input  logic [lfrb_pkg::PIX_W-1:0]  i_pixel,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lfrb_pkg::PIX_W-1:0]  o_out_pixel,
    output logic                        o_out_last,
    output logic                        o_clamped
);

    localparam int WIN_LEN   = 2 * MAX_HALF_WIDTH + 1;
    localparam int WIN_IDX_W = $clog2(WIN_LEN);
    localparam logic signed [lfrb_pkg::ACC_W-1:0] NEG_LIMIT =
        lfrb_pkg::ACC_W'(-(1 <<< lfrb_pkg::FRAC_W));

    logic [lfrb_pkg::PIX_W-1:0]         r_win [WIN_LEN];
    logic [lfrb_pkg::PIX_W-1:0]         r_pix;
    logic [lfrb_pkg::SEEN_W-1:0]        r_seen;
    logic signed [lfrb_pkg::PROD_W-1:0] r_prod;
    logic                               r_prod_vld;
    logic signed [lfrb_pkg::ACC_W-1:0]  r_acc;
    logic                               r_out_valid;
    logic [lfrb_pkg::PIX_W-1:0]         r_out_pixel;
    logic                               r_out_last;
    logic                               r_clamped;

    logic [WIN_IDX_W-1:0]               win_sel;
    logic [lfrb_pkg::PIX_W-1:0]         win_pix;
    logic [lfrb_pkg::COEF_W-1:0]        coef_raw;
    logic signed [lfrb_pkg::PROD_W-1:0] prod;
    logic                               slot_free;
    logic [lfrb_pkg::PIX_W-1:0]         sat_pix;
    logic                               sat_clip;

    // tap j of a 2h+1 kernel reads the window at (len - 2h - 1) + j
    assign win_sel  = WIN_IDX_W'(WIN_LEN - 1 - 2 * int'(i_half) + int'(i_cmd.tap));
    assign win_pix  = r_win[win_sel];
    assign coef_raw = i_coef[i_cmd.tap[3:2]][{i_cmd.tap[1:0], 4'b0000} +: lfrb_pkg::COEF_W];
    assign prod     = $signed(coef_raw) * $signed({1'b0, win_pix});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix <= i_pixel;
            // first pixel of a line forms the left border
            if (r_seen == '0) begin
                for (int k = 0; k < WIN_LEN; k++) begin
                    r_win[k] <= i_pixel;
                end
            end else begin
                for (int k = 0; k < WIN_LEN - 1; k++) begin
                    r_win[k] <= r_win[k+1];
                end
                r_win[WIN_LEN-1] <= i_pixel;
            end
        end else if (i_cmd.hold_shift) begin
            // right border: repeat the last pixel
            for (int k = 0; k < WIN_LEN - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[WIN_LEN-1] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_cmd.load) begin
            if (i_cmd.push_last) begin
                r_seen <= '0;
            end else if (r_seen != lfrb_pkg::SEEN_MAX) begin
                r_seen <= r_seen + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mac_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_step) begin
            r_prod <= prod;
        end
        if (i_cmd.mac_clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + lfrb_pkg::ACC_W'(r_prod);
        end
    end

    // truncate toward zero, then saturate
    always_comb begin
        if (r_acc[lfrb_pkg::ACC_W-1]) begin
            sat_pix  = '0;
            sat_clip = (r_acc <= NEG_LIMIT);
        end else if (r_acc[lfrb_pkg::ACC_W-2:lfrb_pkg::FRAC_W+lfrb_pkg::PIX_W] != '0) begin
            sat_pix  = '1;
            sat_clip = 1'b1;
        end else begin
            sat_pix  = r_acc[lfrb_pkg::FRAC_W +: lfrb_pkg::PIX_W];
            sat_clip = 1'b0;
        end
    end

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_pixel <= sat_pix;
            r_out_last  <= i_cmd.push_last;
            r_clamped   <= sat_clip;
        end
    end

    assign o_status.seen      = r_seen;
    assign o_status.slot_free = slot_free;
    assign o_out_valid        = r_out_valid;
    assign o_out_pixel        = r_out_pixel;
    assign o_out_last         = r_out_last;
    assign o_clamped          = r_clamped;

endmodule

// ===== hw/rtl/lfrb_ctrl.sv =====
// sequencer: accept, border padding, tap loop and result hand-off
module lfrb_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_line_end,
    input  logic [lfrb_pkg::HALF_W-1:0] i_half,
    input  lfrb_pkg::t_dp_status        i_status,
    output lfrb_pkg::t_dp_cmd           o_cmd
);

    lfrb_pkg::t_state               r_state;
    lfrb_pkg::t_state               n_state;
    logic [lfrb_pkg::HALF_W-1:0]    r_pad;
    logic [lfrb_pkg::HALF_W-1:0]    n_pad;
    logic [lfrb_pkg::HALF_W-1:0]    r_rem;
    logic [lfrb_pkg::HALF_W-1:0]    n_rem;
    logic                           r_last;
    logic                           n_last;
    logic [lfrb_pkg::TAP_W-1:0]     r_tap;
    logic [lfrb_pkg::TAP_W-1:0]     n_tap;

    logic                           accept;
    logic                           enough;
    logic [lfrb_pkg::HALF_W-1:0]    flush_m;
    logic [lfrb_pkg::HALF_W-1:0]    pad_cnt;
    logic [lfrb_pkg::TAP_W-1:0]     tap_end;

    assign accept  = (r_state == lfrb_pkg::S_IDLE) && i_in_valid;
    assign enough  = i_status.seen >= lfrb_pkg::SEEN_W'(i_half);
    // outputs still owed on the line end, beyond the first one
    assign flush_m = enough ? i_half : i_status.seen[lfrb_pkg::HALF_W-1:0];
    assign pad_cnt = i_half - flush_m;
    assign tap_end = {i_half, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfrb_pkg::S_IDLE;
            r_pad   <= '0;
            r_rem   <= '0;
            r_last  <= 1'b0;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_pad   <= n_pad;
            r_rem   <= n_rem;
            r_last  <= n_last;
            r_tap   <= n_tap;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfrb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_line_end) begin
                        n_state = (pad_cnt != '0) ? lfrb_pkg::S_PAD : lfrb_pkg::S_MAC;
                    end else if (enough) begin
                        n_state = lfrb_pkg::S_MAC;
                    end
                end
            end
            lfrb_pkg::S_PAD: begin
                if (r_pad == lfrb_pkg::HALF_W'(1)) begin
                    n_state = lfrb_pkg::S_MAC;
                end
            end
            lfrb_pkg::S_MAC: begin
                if (r_tap == tap_end) begin
                    n_state = lfrb_pkg::S_DRAIN;
                end
            end
            lfrb_pkg::S_DRAIN: n_state = lfrb_pkg::S_PUSH;
            lfrb_pkg::S_PUSH: begin
                if (i_status.slot_free) begin
                    n_state = (r_rem != '0) ? lfrb_pkg::S_SHIFT : lfrb_pkg::S_IDLE;
                end
            end
            lfrb_pkg::S_SHIFT: n_state = lfrb_pkg::S_MAC;
            default:           n_state = lfrb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_pad  = r_pad;
        n_rem  = r_rem;
        n_last = r_last;
        n_tap  = r_tap;
        unique case (r_state)
            lfrb_pkg::S_IDLE: begin
                n_tap = '0;
                if (i_in_valid) begin
                    n_pad  = i_line_end ? pad_cnt : '0;
                    n_rem  = i_line_end ? flush_m : '0;
                    n_last = i_line_end && (flush_m == '0);
                end
            end
            lfrb_pkg::S_PAD:   n_pad = r_pad - 1'b1;
            lfrb_pkg::S_MAC:   n_tap = r_tap + 1'b1;
            lfrb_pkg::S_DRAIN: n_tap = '0;
            lfrb_pkg::S_PUSH:  ;
            lfrb_pkg::S_SHIFT: begin
                n_rem  = r_rem - 1'b1;
                n_last = (r_rem == lfrb_pkg::HALF_W'(1));
            end
            default: ;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.tap  = r_tap;
        unique case (r_state)
            lfrb_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load     = accept;
                // on load, push_last tells the datapath the line ends here
                o_cmd.push_last = i_line_end;
            end
            lfrb_pkg::S_PAD:   o_cmd.hold_shift = 1'b1;
            lfrb_pkg::S_MAC: begin
                o_cmd.mac_step  = 1'b1;
                o_cmd.mac_clear = (r_tap == '0);
            end
            lfrb_pkg::S_DRAIN: ;
            lfrb_pkg::S_PUSH: begin
                o_cmd.push      = i_status.slot_free;
                o_cmd.push_last = r_last;
            end
            lfrb_pkg::S_SHIFT: o_cmd.hold_shift = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/line_fir_replicate_border.sv =====
// An 8-bit line filter with 2*half_width+1 signed Q1.14 taps and a replicated border.
// A pixel that completes no window leaves the sequencer idle and ready for the next one. A pixel
// that gives one filtered word goes through the accept step, one multiply per tap through a single
// shared 16x9 multiplier, a step to drain the accumulator and one to load the output register.
// The line-end pixel also spends one window shift per right-border pad and, for each further
// flushed word, a shift step and the multiply, drain and load steps. It gives up to
// half_width+1 words. Loading the output register waits while the previous word is still held
// there. Input is taken again in the cycle after the last word is loaded, while that word may
// still wait to be taken.
module line_fir_replicate_border #(
    parameter int MAX_HALF_WIDTH = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [lfrb_pkg::PIX_W-1:0]          i_pixel,
    input  logic                                i_line_end,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lfrb_pkg::PIX_W-1:0]          o_out_pixel,
    output logic                                o_out_last,
    output logic                                o_clamped,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lfrb_pkg::ADDR_W-1:0]         paddr,
    input  logic [lfrb_pkg::CFG_W-1:0]          pwdata,
    output logic [lfrb_pkg::CFG_W-1:0]          prdata,
    output logic                                pready
);

    logic [lfrb_pkg::HALF_W-1:0] half;
    lfrb_pkg::t_coef_words       coef;
    lfrb_pkg::t_dp_cmd           cmd;
    lfrb_pkg::t_dp_status        status;

    lfrb_cfg #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_half  (half),
        .o_coef  (coef)
    );

    lfrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_line_end (i_line_end),
        .i_half     (half),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lfrb_datapath #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_half      (half),
        .i_coef      (coef),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_pixel (o_out_pixel),
        .o_out_last  (o_out_last),
        .o_clamped   (o_clamped)
    );

endmodule

// ===== hw/rtl/lfrb_checker.sv =====
// port-level checks of the line filter, bound to the top level
`include "line_fir_replicate_border_defines.svh"

module lfrb_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       o_in_ready,
    input  logic                       i_line_end,
    input  logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  logic [lfrb_pkg::PIX_W-1:0] o_out_pixel,
    input  logic                       o_out_last,
    input  logic                       o_clamped
);

    // a stalled result word holds
    `LFRB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_pixel) && $stable(o_out_last) && $stable(o_clamped), "result word changed while stalled")

    // a clamped result sits on one of the rails
    `LFRB_ASSERT_IMP(a_clamp_rail, i_clk, i_rst_n, o_out_valid && o_clamped, (o_out_pixel == '0) || (o_out_pixel == '1), "clamped result off the rails")

    // the line end always flushes, so input must stall right after it
    `LFRB_ASSERT_NXT(a_end_stall, i_clk, i_rst_n, i_in_valid && o_in_ready && i_line_end, !o_in_ready, "input taken during line-end flush")

endmodule

bind line_fir_replicate_border lfrb_checker u_chk (.*);
